@@ rtl/ps2_set1_scancode_decoder_macros.svh @@
// assertion macros for the ps2 set 1 scan code decoder
`ifndef PS2_SET1_SCANCODE_DECODER_MACROS_SVH
`define PS2_SET1_SCANCODE_DECODER_MACROS_SVH

`ifndef SYNTH
`define PS2S1_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2s1 implication check failed");
`define PS2S1_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2s1 next cycle check failed");
`else
`define PS2S1_ASSERT_IMP(lbl, ante, cons)
`define PS2S1_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/ps2s1_pkg.sv @@
// shared types and constants for the ps2 set 1 scan code decoder
package ps2s1_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam logic [1:0] KIND_RX  = 2'd0;
  localparam logic [1:0] KIND_CMD = 2'd1;
  localparam logic [1:0] KIND_LED = 2'd2;

  localparam logic [7:0] SC_EXT      = 8'hE0;
  localparam logic [7:0] SC_PAUSE    = 8'hE1;
  localparam logic [7:0] SC_ACK      = 8'hFA;
  localparam logic [7:0] SC_RESEND   = 8'hFE;
  localparam logic [7:0] CMD_SET_LED = 8'hED;
  localparam logic [7:0] SC_MAKE_MAX = 8'h58;
  localparam logic [7:0] SC_BRK_MIN  = 8'h80;
  localparam logic [7:0] SC_BRK_MAX  = 8'hD7;
  localparam logic [7:0] SC_EXT_MIN  = 8'h10;
  localparam logic [7:0] SC_EXT_MAX  = 8'h6D;
  localparam logic [7:0] SC_EXTB_MIN = 8'h90;
  localparam logic [7:0] SC_EXTB_MAX = 8'hED;
  localparam logic [7:0] SC_PRT_MK1  = 8'h2A;
  localparam logic [7:0] SC_PRT_BK1  = 8'hB7;
  localparam logic [7:0] SC_PRT_MK2  = 8'h37;
  localparam logic [7:0] SC_PRT_BK2  = 8'hAA;
  localparam logic [7:0] SC_PAU_1    = 8'h1D;
  localparam logic [7:0] SC_PAU_2    = 8'h45;
  localparam logic [7:0] SC_PAU_4    = 8'h9D;
  localparam logic [7:0] SC_PAU_5    = 8'hC5;

  localparam logic [1:0] TBL_REGULAR = 2'd0;
  localparam logic [1:0] TBL_EXT     = 2'd1;
  localparam logic [1:0] TBL_PRTSC   = 2'd2;
  localparam logic [1:0] TBL_PAUSE   = 2'd3;

  typedef enum logic [3:0] {
    DS_IDLE  = 4'd0,
    DS_EXT   = 4'd1,
    DS_PRT_A = 4'd2,
    DS_PRT_B = 4'd3,
    DS_PAU_1 = 4'd4,
    DS_PAU_2 = 4'd5,
    DS_PAU_3 = 4'd6,
    DS_PAU_4 = 4'd7,
    DS_PAU_5 = 4'd8
  } dec_state_t;

  typedef struct packed {
    logic       key_valid;
    logic [1:0] key_table;
    logic [6:0] key_index;
    logic       key_released;
    logic       ack;
    logic       resend;
  } dec_out_t;

  typedef struct packed {
    logic       valid;
    logic       from_mem;
    logic [7:0] data;
    logic       dropped;
  } tx_t;

endpackage

@@ rtl/ps2s1_decode.sv @@
// scan code state machine: plain, extended, print screen and pause sequences
module ps2s1_decode
  import ps2s1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rx_en,
  input  logic [7:0] data,
  output dec_out_t   dec
);

  dec_state_t state_r;
  dec_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
    end else if (rx_en) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = DS_IDLE;
    dec       = '0;
    unique case (state_r)
      DS_IDLE: begin
        if (data == SC_EXT) begin
          state_nxt = DS_EXT;
        end else if (data == SC_PAUSE) begin
          state_nxt = DS_PAU_1;
        end else if (data == SC_ACK) begin
          dec.ack = 1'b1;
        end else if (data == SC_RESEND) begin
          dec.resend = 1'b1;
        end else if (data <= SC_MAKE_MAX) begin
          dec.key_valid = 1'b1;
          dec.key_table = TBL_REGULAR;
          dec.key_index = data[6:0];
        end else if (data >= SC_BRK_MIN && data <= SC_BRK_MAX) begin
          dec.key_valid    = 1'b1;
          dec.key_table    = TBL_REGULAR;
          dec.key_index    = data[6:0];
          dec.key_released = 1'b1;
        end
      end
      DS_EXT: begin
        if (data == SC_PRT_MK1 || data == SC_PRT_BK1) begin
          state_nxt = DS_PRT_A;
        end else if (data >= SC_EXT_MIN && data <= SC_EXT_MAX) begin
          dec.key_valid = 1'b1;
          dec.key_table = TBL_EXT;
          dec.key_index = 7'(data - SC_EXT_MIN);
        end else if (data >= SC_EXTB_MIN && data <= SC_EXTB_MAX) begin
          dec.key_valid    = 1'b1;
          dec.key_table    = TBL_EXT;
          dec.key_index    = 7'(data - SC_EXTB_MIN);
          dec.key_released = 1'b1;
        end
      end
      DS_PRT_A: begin
        if (data == SC_EXT) state_nxt = DS_PRT_B;
      end
      DS_PRT_B: begin
        if (data == SC_PRT_MK2 || data == SC_PRT_BK2) begin
          dec.key_valid    = 1'b1;
          dec.key_table    = TBL_PRTSC;
          dec.key_released = (data == SC_PRT_BK2);
        end
      end
      DS_PAU_1: begin
        if (data == SC_PAU_1) state_nxt = DS_PAU_2;
      end
      DS_PAU_2: begin
        if (data == SC_PAU_2) state_nxt = DS_PAU_3;
      end
      DS_PAU_3: begin
        if (data == SC_PAUSE) state_nxt = DS_PAU_4;
      end
      DS_PAU_4: begin
        if (data == SC_PAU_4) state_nxt = DS_PAU_5;
      end
      DS_PAU_5: begin
        if (data == SC_PAU_5) begin
          dec.key_valid    = 1'b1;
          dec.key_table    = TBL_PAUSE;
          dec.key_released = 1'b1;
        end
      end
      default: begin
        state_nxt = DS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ps2s1_cmdq.sv @@
// host-to-keyboard command queue with ack and resend handling
module ps2s1_cmdq
  import ps2s1_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_acc,
  input  logic       push_en,
  input  logic       led_en,
  input  logic [7:0] data,
  input  logic       ack,
  input  logic       resend,
  output tx_t        tx,
  output logic [7:0] rd_data_r,
  output logic       busy
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C    = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_LEFT_C = CW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(n);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]    pend_data_r, pend_data_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] tail, tail_next, head_inc;
  logic          full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (req_acc) rd_data_r <= mem[rd_addr];
  end

  assign tail      = wrap_add(head_r, count_r);
  assign tail_next = wrap_add(tail, CW'(1));
  assign head_inc  = wrap_add(head_r, CW'(1));
  assign full      = (count_r == DEPTH_C);
  assign empty     = (count_r == '0);
  assign busy      = pend_r;

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_data_nxt = pend_data_r;
    wr_en         = pend_r;
    wr_addr       = pend_addr_r;
    wr_data       = pend_data_r;
    rd_addr       = head_r;
    tx            = '0;
    if (push_en) begin
      if (full) begin
        tx.dropped = 1'b1;
      end else begin
        wr_en     = 1'b1;
        wr_addr   = tail;
        wr_data   = data;
        count_nxt = count_r + CW'(1);
        if (empty) begin
          tx.valid = 1'b1;
          tx.data  = data;
        end
      end
    end else if (led_en) begin
      if (full) begin
        tx.dropped = 1'b1;
      end else begin
        wr_en   = 1'b1;
        wr_addr = tail;
        wr_data = CMD_SET_LED;
        if (empty) begin
          tx.valid = 1'b1;
          tx.data  = CMD_SET_LED;
        end
        if (count_r == ONE_LEFT_C) begin
          tx.dropped = 1'b1;
          count_nxt  = count_r + CW'(1);
        end else begin
          // lock byte goes in next cycle through the single write port
          pend_nxt      = 1'b1;
          pend_addr_nxt = tail_next;
          pend_data_nxt = {5'b0, data[2:0]};
          count_nxt     = count_r + CW'(2);
        end
      end
    end else if (ack) begin
      if (!empty) begin
        head_nxt  = head_inc;
        count_nxt = count_r - CW'(1);
        rd_addr   = head_inc;
        if (count_r != CW'(1)) begin
          tx.valid    = 1'b1;
          tx.from_mem = 1'b1;
        end
      end
    end else if (resend) begin
      if (!empty) begin
        tx.valid    = 1'b1;
        tx.from_mem = 1'b1;
      end
    end
  end

endmodule

@@ rtl/ps2_set1_scancode_decoder.sv @@
// top level of the ps2 set 1 scan code decoder and command queue
// usage:
//   input channel (in_valid / in_stall) takes one request per cycle while in_stall is low: in_kind
//   selects a received keyboard byte, a command byte to queue, or an led update
//   (in_data bits 2..0 caps, num, scroll).
//   result channel (out_valid / out_stall) gives exactly one result per request:
//   a key event (table, index, make or break), a byte to send to the keyboard,
//   and a flag when a queued byte was lost to a full queue.
// timing: the result is registered and is on the outputs in the cycle after the request is taken.
// throughput: one request per cycle; an led update that queues both bytes
//   holds in_stall high for the next cycle while the lock byte is written,
//   since the queue memory has one write port.
// stall: while out_stall holds a waiting result, in_stall is high and the
//   result stays put.
// reset: the decoder goes idle and the queue empties; the queue memory itself
//   is not cleared, so there is no clearing pass.
module ps2_set1_scancode_decoder
  import ps2s1_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_key_valid,
  output logic [1:0] out_key_table,
  output logic [6:0] out_key_index,
  output logic       out_key_released,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_cmd_dropped
);

`include "ps2_set1_scancode_decoder_macros.svh"

  logic       accept;
  logic       q_busy;
  logic       rx_en, push_en, led_en;
  dec_out_t   dec;
  tx_t        tx;
  logic [7:0] rd_data;

  logic       out_valid_r;
  logic       key_valid_r;
  logic [1:0] key_table_r;
  logic [6:0] key_index_r;
  logic       key_released_r;
  logic       tx_valid_r;
  logic       tx_sel_r;
  logic [7:0] tx_byte_r;
  logic       dropped_r;

  assign in_stall = (out_valid_r & out_stall) | q_busy;
  assign accept   = in_valid & ~in_stall;
  assign rx_en    = accept & (in_kind == KIND_RX);
  assign push_en  = accept & (in_kind == KIND_CMD);
  assign led_en   = accept & (in_kind == KIND_LED);

  ps2s1_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .rx_en (rx_en),
    .data  (in_data),
    .dec   (dec)
  );

  ps2s1_cmdq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_acc   (accept),
    .push_en   (push_en),
    .led_en    (led_en),
    .data      (in_data),
    .ack       (rx_en & dec.ack),
    .resend    (rx_en & dec.resend),
    .tx        (tx),
    .rd_data_r (rd_data),
    .busy      (q_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_valid_r    <= rx_en & dec.key_valid;
      key_table_r    <= rx_en ? dec.key_table : 2'd0;
      key_index_r    <= rx_en ? dec.key_index : 7'd0;
      key_released_r <= rx_en & dec.key_released;
      tx_valid_r     <= tx.valid;
      tx_sel_r       <= tx.from_mem;
      tx_byte_r      <= tx.data;
      dropped_r      <= tx.dropped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_valid    = key_valid_r;
  assign out_key_table    = key_table_r;
  assign out_key_index    = key_index_r;
  assign out_key_released = key_released_r;
  assign out_tx_valid     = tx_valid_r;
  assign out_tx_byte      = tx_sel_r ? rd_data : tx_byte_r;
  assign out_cmd_dropped  = dropped_r;

  `PS2S1_ASSERT_IMP(a_key_no_tx, out_valid_r && key_valid_r, !tx_valid_r && !dropped_r)
  `PS2S1_ASSERT_IMP(a_mem_tx_valid, out_valid_r && tx_sel_r, tx_valid_r)
  `PS2S1_ASSERT_IMP(a_busy_blocks, q_busy, in_stall && !accept)
  `PS2S1_ASSERT_NXT(a_busy_one_cycle, q_busy, !q_busy)

endmodule

@@ tb/tb_ps2_set1_scancode_decoder.sv @@
// testbench for the ps2 set 1 scan code decoder: directed table, then random requests
`timescale 1ns / 100ps

module tb_ps2_set1_scancode_decoder
  import ps2s1_pkg::*;
();

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DIR_ROWS = 26;
  localparam int RANDOM_REQS = 700;
  localparam int PHASE_LEN = 240;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int QW = $clog2(QUEUE_DEPTH_DEF);
  localparam int DW = $clog2(DIR_ROWS);

  typedef struct packed {
    logic       key_valid;
    logic [1:0] key_table;
    logic [6:0] key_index;
    logic       key_released;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cmd_dropped;
  } kbd_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        typed;
    kbd_result_t res;
  } stim_row_t;

  localparam kbd_result_t NO_RESULT = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind = KIND_RX;
  logic [7:0] in_data = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_key_valid;
  logic [1:0] out_key_table;
  logic [6:0] out_key_index;
  logic       out_key_released;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_cmd_dropped;

  ps2_set1_scancode_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_valid    (out_key_valid),
    .out_key_table    (out_key_table),
    .out_key_index    (out_key_index),
    .out_key_released (out_key_released),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_cmd_dropped  (out_cmd_dropped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{KIND_RX, 8'h00, 1'b1, {1'b1, TBL_REGULAR, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{KIND_RX, SC_MAKE_MAX, 1'b1, {1'b1, TBL_REGULAR, 7'h58, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{KIND_RX, SC_BRK_MIN, 1'b1, {1'b1, TBL_REGULAR, 7'h00, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{KIND_RX, SC_BRK_MAX, 1'b1, {1'b1, TBL_REGULAR, 7'h57, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{KIND_RX, 8'hFF, 1'b1, NO_RESULT},
    '{KIND_RX, SC_ACK, 1'b1, NO_RESULT},
    '{KIND_RX, SC_RESEND, 1'b1, NO_RESULT},
    '{KIND_RX, SC_EXT, 1'b1, NO_RESULT},
    '{KIND_RX, SC_EXT_MAX, 1'b1, {1'b1, TBL_EXT, 7'h5D, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{KIND_RX, SC_EXT, 1'b1, NO_RESULT},
    '{KIND_RX, SC_ACK, 1'b1, NO_RESULT},
    '{KIND_RX, SC_EXT, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PRT_MK1, 1'b1, NO_RESULT},
    '{KIND_RX, SC_EXT, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PRT_MK2, 1'b1, {1'b1, TBL_PRTSC, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{KIND_RX, SC_PAUSE, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PAU_1, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PAU_2, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PAUSE, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PAU_4, 1'b1, NO_RESULT},
    '{KIND_RX, SC_PAU_5, 1'b1, {1'b1, TBL_PAUSE, 7'h00, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{KIND_CMD, 8'h00, 1'b1, {1'b0, TBL_REGULAR, 7'h00, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{KIND_LED, 8'hFF, 1'b0, NO_RESULT},
    '{KIND_RX, SC_RESEND, 1'b0, NO_RESULT},
    '{KIND_RX, SC_ACK, 1'b0, NO_RESULT},
    '{KIND_UNUSED, 8'hFF, 1'b1, NO_RESULT}
  };

  // decoder and command queue as the block should hold them
  dec_state_t  dec_st = DS_IDLE;
  logic [7:0]  cmd_mem [QUEUE_DEPTH_DEF];
  int unsigned q_head = 0;
  int unsigned q_count = 0;

  kbd_result_t owed_results [$];
  stim_row_t   planned_reqs [$];
  stim_row_t   cur_row;
  int          dir_idx = 0;
  int          acc_cnt = 0;
  int          req_cnt = 0;
  int          send_gap_pct = 8;
  int          recv_stall_pct = 73;
  logic        stim_done = 1'b0;
  int          mismatch_cnt = 0;
  int          quiet_cycles = 0;

  function automatic kbd_result_t key_event(logic [1:0] tbl, logic [6:0] idx, logic rel);
    kbd_result_t r;
    r = '0;
    r.key_valid = 1'b1;
    r.key_table = tbl;
    r.key_index = idx;
    r.key_released = rel;
    return r;
  endfunction

  function automatic void enqueue_cmd(input logic [7:0] b, inout kbd_result_t r);
    if (q_count >= QUEUE_DEPTH_DEF) begin
      r.cmd_dropped = 1'b1;
    end else begin
      cmd_mem[QW'((q_head + q_count) % QUEUE_DEPTH_DEF)] = b;
      q_count++;
      if (q_count == 1) begin
        r.tx_valid = 1'b1;
        r.tx_byte = b;
      end
    end
  endfunction

  function automatic kbd_result_t decode_request(logic [1:0] kind, logic [7:0] b);
    kbd_result_t r;
    r = '0;
    case (kind)
      KIND_CMD: enqueue_cmd(b, r);
      KIND_LED: begin
        enqueue_cmd(CMD_SET_LED, r);
        enqueue_cmd({5'b0, b[2:0]}, r);
      end
      KIND_RX: begin
        case (dec_st)
          DS_IDLE: begin
            if (b == SC_EXT) begin
              dec_st = DS_EXT;
            end else if (b == SC_PAUSE) begin
              dec_st = DS_PAU_1;
            end else if (b == SC_ACK) begin
              if (q_count > 0) begin
                q_head = (q_head + 1) % QUEUE_DEPTH_DEF;
                q_count--;
                if (q_count > 0) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = cmd_mem[QW'(q_head)];
                end
              end
            end else if (b == SC_RESEND) begin
              if (q_count > 0) begin
                r.tx_valid = 1'b1;
                r.tx_byte = cmd_mem[QW'(q_head)];
              end
            end else if (b <= SC_MAKE_MAX) begin
              r = key_event(TBL_REGULAR, b[6:0], 1'b0);
            end else if (b >= SC_BRK_MIN && b <= SC_BRK_MAX) begin
              r = key_event(TBL_REGULAR, b[6:0], 1'b1);
            end
          end
          DS_EXT: begin
            dec_st = DS_IDLE;
            if (b == SC_PRT_MK1 || b == SC_PRT_BK1) begin
              dec_st = DS_PRT_A;
            end else if (b >= SC_EXT_MIN && b <= SC_EXT_MAX) begin
              r = key_event(TBL_EXT, 7'(b - SC_EXT_MIN), 1'b0);
            end else if (b >= SC_EXTB_MIN && b <= SC_EXTB_MAX) begin
              r = key_event(TBL_EXT, 7'(b - SC_EXTB_MIN), 1'b1);
            end
          end
          DS_PRT_A: dec_st = (b == SC_EXT) ? DS_PRT_B : DS_IDLE;
          DS_PRT_B: begin
            dec_st = DS_IDLE;
            if (b == SC_PRT_MK2 || b == SC_PRT_BK2) begin
              r = key_event(TBL_PRTSC, 7'd0, b == SC_PRT_BK2);
            end
          end
          DS_PAU_1: dec_st = (b == SC_PAU_1) ? DS_PAU_2 : DS_IDLE;
          DS_PAU_2: dec_st = (b == SC_PAU_2) ? DS_PAU_3 : DS_IDLE;
          DS_PAU_3: dec_st = (b == SC_PAUSE) ? DS_PAU_4 : DS_IDLE;
          DS_PAU_4: dec_st = (b == SC_PAU_4) ? DS_PAU_5 : DS_IDLE;
          DS_PAU_5: begin
            dec_st = DS_IDLE;
            if (b == SC_PAU_5) begin
              r = key_event(TBL_PAUSE, 7'd0, 1'b1);
            end
          end
          default: dec_st = DS_IDLE;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void plan_req(logic [1:0] kind, logic [7:0] data);
    planned_reqs.push_back('{kind, data, 1'b0, NO_RESULT});
  endfunction

  // one random key sequence or queue operation, mostly well formed
  function automatic void plan_sequence();
    int unsigned pick;
    int          n;
    logic [7:0]  sq [6];
    pick = $urandom_range(99);
    if (pick < 25) begin
      plan_req(KIND_RX, $urandom_range(1) ? 8'($urandom_range(SC_MAKE_MAX))
                                          : 8'($urandom_range(SC_BRK_MAX, SC_BRK_MIN)));
    end else if (pick < 40) begin
      plan_req(KIND_RX, SC_EXT);
      case ($urandom_range(4))
        0: plan_req(KIND_RX, 8'($urandom));
        1, 2: plan_req(KIND_RX, 8'($urandom_range(SC_EXT_MAX, SC_EXT_MIN)));
        default: plan_req(KIND_RX, 8'($urandom_range(SC_EXTB_MAX, SC_EXTB_MIN)));
      endcase
    end else if (pick < 56) begin
      if (pick < 48) begin
        sq[0] = SC_EXT;
        sq[1] = $urandom_range(1) ? SC_PRT_MK1 : SC_PRT_BK1;
        sq[2] = SC_EXT;
        sq[3] = $urandom_range(1) ? SC_PRT_MK2 : SC_PRT_BK2;
        n = 4;
      end else begin
        sq = '{SC_PAUSE, SC_PAU_1, SC_PAU_2, SC_PAUSE, SC_PAU_4, SC_PAU_5};
        n = 6;
      end
      if ($urandom_range(4) == 0) begin
        sq[3'($urandom_range(n - 1))] = 8'($urandom);
      end
      for (int i = 0; i < n; i++) begin
        plan_req(KIND_RX, sq[3'(i)]);
      end
    end else if (pick < 68) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        plan_req(KIND_CMD, 8'($urandom));
      end
    end else if (pick < 74) begin
      plan_req(KIND_LED, 8'($urandom));
    end else if (pick < 84) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        plan_req(KIND_RX, SC_ACK);
      end
    end else if (pick < 88) begin
      plan_req(KIND_RX, SC_RESEND);
    end else if (pick < 91) begin
      plan_req(KIND_UNUSED, 8'($urandom));
    end else if (pick < 96) begin
      plan_req(KIND_RX, 8'($urandom));
    end else if (pick < 98) begin
      // fill up to one free slot, then an led update, sometimes overflow further
      for (int i = int'(q_count); i < QUEUE_DEPTH_DEF - 1; i++) begin
        plan_req(KIND_CMD, 8'($urandom));
      end
      plan_req(KIND_LED, 8'($urandom));
      if ($urandom_range(1)) begin
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
          plan_req(KIND_CMD, 8'($urandom));
        end
      end
    end else begin
      for (int i = 0; i <= int'(q_count); i++) begin
        plan_req(KIND_RX, SC_ACK);
      end
    end
  endfunction

  always @(posedge clk) begin : drive_requests
    kbd_result_t predicted;
    stim_row_t   nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = decode_request(in_kind, in_data);
        owed_results.push_back(cur_row.typed ? cur_row.res : predicted);
        acc_cnt++;
        if (dir_idx >= DIR_ROWS && in_kind != KIND_UNUSED) begin
          req_cnt++;
        end
        send_gap_pct <= (acc_cnt < PHASE_LEN) ? 8 : (acc_cnt < 2 * PHASE_LEN) ? 73 : 0;
        recv_stall_pct <= (acc_cnt < PHASE_LEN) ? 73 : (acc_cnt < 2 * PHASE_LEN) ? 8 : 0;
      end
      if (!in_valid || !in_stall) begin
        if (dir_idx >= DIR_ROWS && planned_reqs.size() == 0 && req_cnt >= RANDOM_REQS) begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end else if ($urandom_range(99) < send_gap_pct) begin
          in_valid <= 1'b0;
        end else begin
          if (dir_idx < DIR_ROWS) begin
            nxt = directed_rows[DW'(dir_idx)];
            dir_idx++;
          end else begin
            if (planned_reqs.size() == 0) begin
              plan_sequence();
            end
            nxt = planned_reqs.pop_front();
          end
          cur_row = nxt;
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_data <= nxt.data;
        end
      end
    end
  end

  function automatic string show_result(kbd_result_t r);
    return {$sformatf("key_valid=%0d table=%0d index=%0d released=%0d ",
                      r.key_valid, r.key_table, r.key_index, r.key_released),
            $sformatf("tx_valid=%0d tx=%02h dropped=%0d",
                      r.tx_valid, r.tx_byte, r.cmd_dropped)};
  endfunction

  always @(posedge clk) begin : check_results
    kbd_result_t want;
    kbd_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_key_valid, out_key_table, out_key_index, out_key_released,
               out_tx_valid, out_tx_byte, out_cmd_dropped};
        if (owed_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result: %s", show_result(got));
          end
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", show_result(want));
              $display("  actual   %s", show_result(got));
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && owed_results.size() == 0)) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
